### src/scfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared constants and types of the serial command frame relay control.
// ----------------------------------------------------------------------------
package scfr_pkg;

  localparam int MAX_PAYLOAD = 9;
  localparam int NUM_RELAYS  = 4;
  localparam int NUM_LEDS    = 2;

  localparam int RELAY_W = 4;
  localparam int LED_W   = 2;
  localparam int STORE_IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam logic [7:0] CH_START = 8'h63;  // 'c'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CMD_RELAY = 8'h72; // 'r'
  localparam logic [7:0] CMD_LED   = 8'h6c; // 'l'
  localparam logic [7:0] CMD_TEMP  = 8'h74; // 't'
  localparam logic [7:0] NUM_DIGITS = 8'd10;
  localparam logic [3:0] MAX_SHORT_LEN = 4'd2;

  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef struct packed {
    logic [RELAY_W-1:0] relay_bits;
    logic [LED_W-1:0]   led_bits;
    logic [1:0]         frame_status;
    logic               temp_request;
  } result_t;

endpackage

### src/scfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_parser
// Frame parser and executor: state registers plus the single-pass update
// that yields one result for each transferred byte.
// ----------------------------------------------------------------------------
module scfr_parser
  import scfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output result_t    res
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMD  = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  logic [1:0]         phase, phase_next;
  logic [7:0]         command_byte, command_byte_next;
  logic [3:0]         payload_length, payload_length_next;
  logic [3:0]         payload_count, payload_count_next;
  logic [7:0]         store [MAX_PAYLOAD];
  logic [7:0]         store_next [MAX_PAYLOAD];
  logic [RELAY_W-1:0] relay_state, relay_next;
  logic [LED_W-1:0]   led_state, led_next;

  logic [7:0] digit;
  logic [3:0] count_inc;
  logic       exec;
  logic [7:0] idx;
  logic       on;
  logic [1:0] status;
  logic       temp;

  assign digit     = rx_byte - CH_ZERO;
  assign count_inc = payload_count + 4'd1;

  always_comb begin
    phase_next          = phase;
    command_byte_next   = command_byte;
    payload_length_next = payload_length;
    payload_count_next  = payload_count;
    store_next          = store;
    exec                = 1'b0;
    unique case (phase)
      PH_CMD: begin
        command_byte_next = rx_byte;
        phase_next        = PH_LEN;
      end
      PH_LEN: begin
        phase_next = PH_IDLE;
        if (digit < NUM_DIGITS && digit <= 8'(MAX_PAYLOAD)) begin
          payload_length_next = digit[3:0];
          payload_count_next  = 4'd0;
          if (digit == 8'd0) begin
            exec = 1'b1;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (payload_count < 4'(MAX_PAYLOAD)) begin
          store_next[payload_count[STORE_IDX_W-1:0]] = rx_byte;
        end
        payload_count_next = count_inc;
        if (count_inc >= payload_length) begin
          phase_next = PH_IDLE;
          exec       = 1'b1;
        end
      end
      default: begin
        phase_next = (rx_byte == CH_START) ? PH_CMD : PH_IDLE;
      end
    endcase
  end

  assign idx = store_next[0] - CH_ZERO;
  assign on  = (store_next[1] - CH_ZERO) != 8'd0;

  always_comb begin
    relay_next = relay_state;
    led_next   = led_state;
    status     = ST_NONE;
    temp       = 1'b0;
    if (exec) begin
      unique case (command_byte_next)
        CMD_RELAY: begin
          if (payload_length_next > MAX_SHORT_LEN || idx >= 8'(NUM_RELAYS)) begin
            status = ST_REJECT;
          end else begin
            status = ST_DONE;
            if (idx < 8'(RELAY_W)) begin
              relay_next[idx[$clog2(RELAY_W)-1:0]] = on;
            end
          end
        end
        CMD_LED: begin
          if (payload_length_next > MAX_SHORT_LEN) begin
            status = ST_REJECT;
          end else begin
            status = ST_DONE;
            if (idx < 8'(NUM_LEDS) && idx < 8'(LED_W)) begin
              led_next[idx[$clog2(LED_W)-1:0]] = on;
            end
          end
        end
        CMD_TEMP: begin
          status = ST_DONE;
          temp   = 1'b1;
        end
        default: begin
          status = ST_REJECT;
        end
      endcase
    end
  end

  assign res.relay_bits   = relay_next;
  assign res.led_bits     = led_next;
  assign res.frame_status = status;
  assign res.temp_request = temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      command_byte   <= 8'd0;
      payload_length <= 4'd0;
      payload_count  <= 4'd0;
      relay_state    <= '0;
      led_state      <= '0;
      for (int i = 0; i < MAX_PAYLOAD; i++) begin
        store[i] <= 8'd0;
      end
    end else if (accept) begin
      phase          <= phase_next;
      command_byte   <= command_byte_next;
      payload_length <= payload_length_next;
      payload_count  <= payload_count_next;
      relay_state    <= relay_next;
      led_state      <= led_next;
      store          <= store_next;
    end
  end

endmodule

### src/scfr_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module scfr_out_buf
  import scfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    main_valid;
  logic    skid_valid;
  result_t skid_data;
  logic    take;

  assign take      = main_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !main_valid) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= push;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !main_valid) begin
      out_data <= skid_valid ? skid_data : push_data;
      if (skid_valid) begin
        skid_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

### src/serial_command_frame_relay_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_frame_relay_control
// Parses 'c' cmd len payload frames from serial bytes and drives relays,
// LEDs and a temperature request.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel: one received byte per transfer (rx_valid high, rx_stall low).
//   res channel: one result per byte, in order, with the relay and LED
//   outputs after that byte, the frame status and the temperature request.
//   The result of a byte is registered in the output buffer before it shows on res.
//   Throughput: one byte per cycle while rx_stall is low; the parser state
//   update is a single pass of compare and select logic between the state registers.
//   A two-entry output buffer lets a byte be taken while one result waits;
//   rx_stall rises only when both entries are held by a stalled receiver.
//   Reset: parser waits for a start byte, store cleared, relays and LEDs off,
//   no result pending.
// ----------------------------------------------------------------------------
module serial_command_frame_relay_control
  import scfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_stall,
  input  logic [7:0]         rx_byte,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [RELAY_W-1:0] relay_bits,
  output logic [LED_W-1:0]   led_bits,
  output logic [1:0]         frame_status,
  output logic               temp_request
);

  logic    accept;
  logic    full;
  result_t res_next;
  result_t res_q;

  assign rx_stall = full;
  assign accept   = rx_valid && !full;

  scfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .res     (res_next)
  );

  scfr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res_next),
    .full      (full),
    .out_valid (res_valid),
    .out_stall (res_stall),
    .out_data  (res_q)
  );

  assign relay_bits   = res_q.relay_bits;
  assign led_bits     = res_q.led_bits;
  assign frame_status = res_q.frame_status;
  assign temp_request = res_q.temp_request;

endmodule

### src/scfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_checker
// Port-level checks of the serial command frame relay control.
// ----------------------------------------------------------------------------
module scfr_checker
  import scfr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               rx_valid,
  input logic               rx_stall,
  input logic               res_valid,
  input logic               res_stall,
  input logic [RELAY_W-1:0] relay_bits,
  input logic [LED_W-1:0]   led_bits,
  input logic [1:0]         frame_status,
  input logic               temp_request
);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (frame_status == ST_NONE || frame_status == ST_DONE ||
                   frame_status == ST_REJECT))
    else $error("invalid frame status");

  a_temp_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && temp_request |-> frame_status == ST_DONE)
    else $error("temp request without executed frame");

  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    rx_valid && rx_stall |-> res_valid)
    else $error("rx stalled with no result pending");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(relay_bits) &&
      $stable(led_bits) && $stable(frame_status) && $stable(temp_request))
    else $error("stalled result changed");

endmodule

bind serial_command_frame_relay_control scfr_checker u_scfr_checker (
  .clk          (clk),
  .rst          (rst),
  .rx_valid     (rx_valid),
  .rx_stall     (rx_stall),
  .res_valid    (res_valid),
  .res_stall    (res_stall),
  .relay_bits   (relay_bits),
  .led_bits     (led_bits),
  .frame_status (frame_status),
  .temp_request (temp_request)
);
